>>> hw/rtl/rmf_pkg.sv
// rmf_pkg: shared types, constants and compare helpers for the RGB 3x3 median filter.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
package rmf_pkg;

    // Default line buffer depth (widest row handled)
    localparam int MAX_WIDTH_DEF = 2048;

    // Window geometry: center entry and last entry of the 3x3 window
    localparam int CENTER_IDX = 4;
    localparam int WIN_LAST   = 8;

    // Queue between the front and the median back end
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Operation codes of the input word
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Configuration register indexes
    localparam int CFG_IW = 4;
    localparam int CFG_DW = 16;
    localparam logic [CFG_IW-1:0] CFG_IDX_WIDTH  = 4'd0;
    localparam logic [CFG_IW-1:0] CFG_IDX_HEIGHT = 4'd1;

    // Pixel packed red, green, blue: unsigned compare is lexicographic order
    typedef logic [23:0] t_pix;
    typedef logic [2:0][23:0] t_trio;

    typedef struct packed {
        logic       operation;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } t_out;

    // Work word handed from front to back
    typedef struct packed {
        logic                    last;
        logic                    border;
        logic [WIN_LAST:0][23:0] win;
    } t_work;

    // Sort three pixels, index 0 smallest
    function automatic t_trio sort3(input t_pix a, input t_pix b, input t_pix c);
        t_pix lo;
        t_pix hi;
        t_trio res;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c < lo) begin
            res = {hi, lo, c};
        end else if (c < hi) begin
            res = {hi, c, lo};
        end else begin
            res = {c, hi, lo};
        end
        return res;
    endfunction

    function automatic t_pix max3(input t_pix a, input t_pix b, input t_pix c);
        t_pix m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic t_pix min3(input t_pix a, input t_pix b, input t_pix c);
        t_pix m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic t_pix med3(input t_pix a, input t_pix b, input t_pix c);
        t_trio s;
        s = sort3(a, b, c);
        return s[1];
    endfunction

endpackage

>>> hw/rtl/rmf_front.sv
// rmf_front: accepts words, keeps frame counters, line buffers and the 3x3 window.
// Emits one work word per result into the queue. Depends on rmf_pkg.
`timescale 1ns / 1ps
module rmf_front import rmf_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in               i_data,
    input  logic              i_cfg_valid,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic [QCW-1:0]    i_q_count,
    output logic              o_q_push,
    output t_work             o_q_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = WW + 1;

    // Configuration and frame position
    logic [11:0]   r_cfg_w, n_cfg_w;
    logic [15:0]   r_cfg_h, n_cfg_h;
    logic [AW-1:0] r_col, n_col;
    logic [15:0]   r_row, n_row;
    logic [PW-1:0] r_pend, n_pend;
    logic [AW-1:0] r_dr_col, n_dr_col;
    logic [15:0]   r_dr_row, n_dr_row;

    // Second stage
    logic          r_s1_valid;
    logic          r_s1_push;
    logic          r_s1_emit;
    logic          r_s1_border;
    logic          r_s1_last;
    logic          r_s1_selmid;
    logic [AW-1:0] r_s1_addr;
    t_pix          r_s1_pix;

    // Line buffers as one word {upper, middle} per column
    logic [47:0]   mem [MAX_WIDTH];
    logic [47:0]   r_rd;
    logic          r_byp;
    logic [47:0]   r_byp_data;
    logic [WIN_LAST:0][23:0] r_win;

    logic          accept;
    logic          is_push;
    logic [31:0]   w32;
    logic [WW-1:0] eff_w;
    logic [WW-1:0] wm1;
    logic [15:0]   eff_h;
    logic [15:0]   hm1;
    logic          restart;
    logic [15:0]   cur_r;
    logic [AW-1:0] cur_c;
    logic [WW-1:0] cc;
    logic          emit_px;
    logic [15:0]   orow;
    logic [WW-1:0] ocol;
    logic          border;
    logic [WW-1:0] c_inc;
    logic [15:0]   r_inc;
    logic          has_pend;
    logic [WW-1:0] d_inc;
    logic [AW-1:0] addr;
    logic          s0_valid;
    logic          mem_we;
    logic [47:0]   rd;
    logic [47:0]   wdata;
    logic [WIN_LAST:0][23:0] win_next;
    t_work         entry;

    // Hold off input while queue plus stage two could fill the queue
    assign o_stall = (32'(i_q_count) + 32'(r_s1_valid)) >= QDEPTH;
    assign accept  = i_valid && !o_stall;
    assign is_push = (i_data.operation == OP_PUSH);

    // Clamp the configured size
    always_comb begin
        if (r_cfg_w == 12'd0) begin
            w32 = 32'd1;
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            w32 = 32'(MAX_WIDTH);
        end else begin
            w32 = 32'(r_cfg_w);
        end
    end
    assign eff_w = w32[WW-1:0];
    assign wm1   = eff_w - WW'(1);
    assign eff_h = (r_cfg_h == 16'd0) ? 16'd1 : r_cfg_h;
    assign hm1   = eff_h - 16'd1;

    // Position of the pushed pixel and of its output
    assign restart = (r_pend != '0) || (WW'(r_col) >= eff_w) || (r_row >= eff_h);
    assign cur_r   = restart ? 16'd0 : r_row;
    assign cur_c   = restart ? '0 : r_col;
    assign cc      = WW'(cur_c);
    assign emit_px = (cur_r >= 16'd2) || ((cur_r == 16'd1) && (cur_c != '0));
    assign orow    = (cur_c != '0) ? (cur_r - 16'd1) : (cur_r - 16'd2);
    assign ocol    = (cur_c != '0) ? (cc - WW'(1)) : wm1;
    assign border  = (orow == 16'd0) || (orow == hm1) || (ocol == '0) || (ocol == wm1);
    assign c_inc   = cc + WW'(1);
    assign r_inc   = cur_r + 16'd1;

    assign has_pend = (r_pend != '0);
    assign d_inc    = WW'(r_dr_col) + WW'(1);
    assign addr     = is_push ? cur_c : r_dr_col;
    assign s0_valid = accept && (is_push || has_pend);

    // Next state of counters and configuration
    always_comb begin
        n_cfg_w  = r_cfg_w;
        n_cfg_h  = r_cfg_h;
        n_col    = r_col;
        n_row    = r_row;
        n_pend   = r_pend;
        n_dr_col = r_dr_col;
        n_dr_row = r_dr_row;
        if (accept) begin
            if (is_push) begin
                n_pend = '0;
                if (c_inc == eff_w) begin
                    n_col = '0;
                    if (r_inc == eff_h) begin
                        n_row = 16'd0;
                        if (eff_h == 16'd1) begin
                            n_pend   = PW'(eff_w);
                            n_dr_row = 16'd0;
                            n_dr_col = '0;
                        end else begin
                            n_pend   = PW'(eff_w) + PW'(1);
                            n_dr_row = eff_h - 16'd2;
                            n_dr_col = wm1[AW-1:0];
                        end
                    end else begin
                        n_row = r_inc;
                    end
                end else begin
                    n_col = c_inc[AW-1:0];
                    n_row = cur_r;
                end
            end else if (has_pend) begin
                n_pend = r_pend - PW'(1);
                if (d_inc == eff_w) begin
                    n_dr_col = '0;
                    n_dr_row = r_dr_row + 16'd1;
                end else begin
                    n_dr_col = d_inc[AW-1:0];
                end
            end
        end
        // Register write restarts the frame
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDX_WIDTH: begin
                    n_cfg_w = i_cfg_data[11:0];
                    n_col   = '0;
                    n_row   = 16'd0;
                    n_pend  = '0;
                end
                CFG_IDX_HEIGHT: begin
                    n_cfg_h = i_cfg_data;
                    n_col   = '0;
                    n_row   = 16'd0;
                    n_pend  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= 12'd640;
            r_cfg_h    <= 16'd480;
            r_col      <= '0;
            r_row      <= 16'd0;
            r_pend     <= '0;
            r_dr_col   <= '0;
            r_dr_row   <= 16'd0;
            r_s1_valid <= 1'b0;
            r_byp      <= 1'b0;
            r_win      <= '0;
        end else begin
            r_cfg_w    <= n_cfg_w;
            r_cfg_h    <= n_cfg_h;
            r_col      <= n_col;
            r_row      <= n_row;
            r_pend     <= n_pend;
            r_dr_col   <= n_dr_col;
            r_dr_row   <= n_dr_row;
            r_s1_valid <= s0_valid;
            // Forward the word written this edge when it is read this edge
            r_byp      <= accept && mem_we && (r_s1_addr == addr);
            if (mem_we) begin
                r_win <= win_next;
            end
        end
    end

    // Stage two payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_push   <= is_push;
            r_s1_emit   <= is_push ? emit_px : 1'b1;
            r_s1_border <= is_push ? border : 1'b1;
            r_s1_last   <= !is_push && (r_pend == PW'(1));
            r_s1_selmid <= (r_dr_row == hm1);
            r_s1_addr   <= addr;
            r_s1_pix    <= {i_data.in_red, i_data.in_green, i_data.in_blue};
        end
        r_byp_data <= wdata;
    end

    // Line buffer: read at accept, written in the cycle after
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= mem[addr];
        end
        if (mem_we) begin
            mem[r_s1_addr] <= wdata;
        end
    end

    assign mem_we = r_s1_valid && r_s1_push;
    assign rd     = r_byp ? r_byp_data : r_rd;
    assign wdata  = {rd[23:0], r_s1_pix};

    // Shift the window and load the new column
    always_comb begin
        win_next = r_win;
        for (int k = 0; k < 3; k++) begin
            win_next[k*3]     = r_win[k*3+1];
            win_next[k*3 + 1] = r_win[k*3+2];
        end
        win_next[2]        = rd[47:24];
        win_next[5]        = rd[23:0];
        win_next[WIN_LAST] = r_s1_pix;
        entry.win    = win_next;
        entry.border = r_s1_border;
        entry.last   = r_s1_last;
        if (!r_s1_push) begin
            entry.win[CENTER_IDX] = r_s1_selmid ? rd[23:0] : rd[47:24];
        end
    end

    assign o_q_push = r_s1_valid && r_s1_emit;
    assign o_q_data = entry;

endmodule

>>> hw/rtl/rmf_queue.sv
// rmf_queue: short FIFO of work words between the front and the median back end.
// Depends on rmf_pkg for the word type and depth.
`timescale 1ns / 1ps
module rmf_queue import rmf_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  t_work          i_data,
    input  logic           i_pop,
    output t_work          o_data,
    output logic [QCW-1:0] o_count
);

    t_work          r_ent [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            r_cnt <= r_cnt + QCW'(i_push) - QCW'(i_pop);
        end
    end

    // Store the word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_data;
        end
    end

    assign o_data  = r_ent[r_rp];
    assign o_count = r_cnt;

endmodule

>>> hw/rtl/rmf_median.sv
// rmf_median: three-stage elastic median of nine, row sort then column select.
// Holds the output word under stall. Depends on rmf_pkg.
`timescale 1ns / 1ps
module rmf_median import rmf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_valid,
    input  t_work i_q_data,
    output logic  o_q_pop,
    output logic  o_valid,
    input  logic  i_stall,
    output t_out  o_data
);

    // Stage one: rows sorted
    logic             r_v1;
    logic [2:0][2:0][23:0] r_srt;
    t_pix             r_b1_ctr;
    logic             r_b1_border;
    logic             r_b1_last;
    // Stage two: column candidates
    logic             r_v2;
    t_pix             r_lo_max;
    t_pix             r_md_med;
    t_pix             r_hi_min;
    t_pix             r_b2_ctr;
    logic             r_b2_border;
    logic             r_b2_last;
    // Output word
    logic             r_ov;
    t_out             r_out;

    logic             out_en;
    logic             en2;
    logic             en1;
    logic [2:0][2:0][23:0] srt;
    t_pix             res;

    assign out_en  = !r_ov || !i_stall;
    assign en2     = !r_v2 || out_en;
    assign en1     = !r_v1 || en2;
    assign o_q_pop = i_q_valid && en1;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            srt[k] = sort3(i_q_data.win[k*3], i_q_data.win[k*3+1], i_q_data.win[k*3+2]);
        end
    end

    assign res = r_b2_border ? r_b2_ctr : med3(r_lo_max, r_md_med, r_hi_min);

    // Advance valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_q_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (out_en) begin
                r_ov <= r_v2;
            end
        end
    end

    // Advance payloads
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_srt       <= srt;
            r_b1_ctr    <= i_q_data.win[CENTER_IDX];
            r_b1_border <= i_q_data.border;
            r_b1_last   <= i_q_data.last;
        end
        if (en2 && r_v1) begin
            r_lo_max    <= max3(r_srt[0][0], r_srt[1][0], r_srt[2][0]);
            r_md_med    <= med3(r_srt[0][1], r_srt[1][1], r_srt[2][1]);
            r_hi_min    <= min3(r_srt[0][2], r_srt[1][2], r_srt[2][2]);
            r_b2_ctr    <= r_b1_ctr;
            r_b2_border <= r_b1_border;
            r_b2_last   <= r_b1_last;
        end
        if (out_en && r_v2) begin
            r_out <= '{out_red: res[23:16], out_green: res[15:8], out_blue: res[7:0],
                       frame_end: r_b2_last};
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

>>> hw/rtl/rgb_median3x3_filter.sv
// rgb_median3x3_filter: top level of the streaming RGB 3x3 median filter.
// Depends on rmf_pkg, rmf_front, rmf_queue and rmf_median.
//
// Input channel i_valid / o_stall carries one word: a pixel push or a drain tick.
// Output channel o_valid / i_stall carries filtered pixels in raster order; the
// last pixel of a frame has frame_end set and always comes from a drain tick.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index (0 width, 1 height)
// and i_cfg_data; a write restarts the frame. Write only while the block is idle.
// Throughput: one word per clock while o_stall is low. The line buffer is read
// at accept and written in the cycle after; words read it, pushes write it. A
// word passes the front's second stage, the queue and the median. The first
// width+1 pushes of a frame give no result; after the last row, width+1 drain
// ticks (width for a one-row frame) flush what is owed.
// Reset: frame position and pending drains clear, width 640, height 480; the
// line buffers are not cleared.
// Stall: the output word holds under i_stall; o_stall rises once the four-word
// queue's count plus the front's second stage word would reach four.
`timescale 1ns / 1ps
module rgb_median3x3_filter import rmf_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in               i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out              o_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    logic           q_push;
    logic           q_pop;
    t_work          q_in;
    t_work          q_out;
    logic [QCW-1:0] q_count;

    assign o_cfg_ready = 1'b1;

    // Accept words, keep line buffers and window
    rmf_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_q_count  (q_count),
        .o_q_push   (q_push),
        .o_q_data   (q_in)
    );

    // Decouple front and back
    rmf_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .i_pop  (q_pop),
        .o_data (q_out),
        .o_count(q_count)
    );

    // Median and output register
    rmf_median u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_count != '0),
        .i_q_data (q_out),
        .o_q_pop  (q_pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_data   (o_data)
    );

`ifndef SYNTH
    a_q_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_count < QCW'(QDEPTH)) || q_pop)
        else $error("queue overflow");

    a_q_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_count != '0)
        else $error("queue underflow");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
`endif

endmodule

>>> sim/tb_top.sv
// tb_top: self-checking testbench for rgb_median3x3_filter.
// Depends on rmf_pkg and the filter RTL; predicts each filtered word and compares in order.
`timescale 1ns / 1ps
module tb_top;
    import rmf_pkg::*;

    localparam int MW        = 2048;
    localparam int CYC_LIMIT = 2000000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    t_in               i_data = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    t_out              o_data;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;

    rgb_median3x3_filter DUT (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state
    logic [11:0] pr_width;
    logic [15:0] pr_height;
    t_pix        upper_line [MW];
    t_pix        middle_line [MW];
    t_pix        win [3][3];
    int unsigned col_pos, row_pos, owed;

    t_out pixel_q[$];
    int   errors = 0;
    int   cycles = 0;
    bit   calm = 0;       // no idling in the last part
    bit   hold_rx = 0;    // long receiver hold-off
    int   sent = 0;

    task automatic report(input string what, input t_out got, input t_out exp);
        errors++;
        $display("MISMATCH %s: got %h expected %h", what, got, exp);
    endtask

    function automatic int unsigned eff_w();
        if (pr_width == 0) return 1;
        if (pr_width > MW) return MW;
        return pr_width;
    endfunction

    function automatic int unsigned eff_h();
        return (pr_height == 0) ? 1 : pr_height;
    endfunction

    function automatic t_out mk(input t_pix p, input logic last);
        t_out o;
        o.out_red = p[23:16];
        o.out_green = p[15:8];
        o.out_blue = p[7:0];
        o.frame_end = last;
        return o;
    endfunction

    function automatic t_pix median9();
        t_pix v[9];
        t_pix key;
        int b;
        for (int a = 0; a < 9; a++) v[a] = win[a/3][a%3];
        for (int a = 1; a < 9; a++) begin
            key = v[a];
            b = a - 1;
            while (b >= 0 && v[b] > key) begin
                v[b+1] = v[b];
                b--;
            end
            v[b+1] = key;
        end
        return v[4];
    endfunction

    // Advance the filter model by one accepted word
    task automatic predict_filter(input t_in w);
        int unsigned wd, ht, tot, m, r, c, orow, ocol;
        t_pix pix, up, mid, px;
        wd = eff_w();
        ht = eff_h();
        tot = wd * ht;
        if (w.operation == OP_DRAIN) begin
            if (owed == 0) return;
            m = tot - owed;
            r = m / wd;
            c = m % wd;
            px = (r == ht - 1) ? middle_line[c] : upper_line[c];
            owed--;
            pixel_q.push_back(mk(px, owed == 0));
        end else begin
            pix = {w.in_red, w.in_green, w.in_blue};
            if (owed != 0 || col_pos >= wd || row_pos >= ht) begin
                col_pos = 0; row_pos = 0; owed = 0;
            end
            r = row_pos;
            c = col_pos;
            up = upper_line[c];
            mid = middle_line[c];
            upper_line[c] = mid;
            middle_line[c] = pix;
            for (int k = 0; k < 3; k++) begin
                win[k][0] = win[k][1];
                win[k][1] = win[k][2];
            end
            win[0][2] = up;
            win[1][2] = mid;
            win[2][2] = pix;
            if (r >= 2 || (r == 1 && c >= 1)) begin
                if (c >= 1) begin
                    orow = r - 1; ocol = c - 1;
                end else begin
                    orow = r - 2; ocol = wd - 1;
                end
                if (orow == 0 || orow == ht - 1 || ocol == 0 || ocol == wd - 1)
                    px = win[1][1];
                else
                    px = median9();
                pixel_q.push_back(mk(px, 1'b0));
            end
            c++;
            if (c == wd) begin
                c = 0;
                r++;
                if (r == ht) begin
                    r = 0;
                    owed = (wd + 1 < tot) ? wd + 1 : tot;
                end
            end
            col_pos = c;
            row_pos = r;
        end
    endtask

    // Cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("rgb_median3x3_filter verification failed");
            $finish;
        end
    end

    // Check each accepted word
    always @(posedge i_clk) begin
        t_out exp;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixel_q.size() == 0) begin
                report("unexpected word", o_data, '0);
            end else begin
                exp = pixel_q.pop_front();
                if (o_data.out_red !== exp.out_red) report("red", o_data, exp);
                else if (o_data.out_green !== exp.out_green) report("green", o_data, exp);
                else if (o_data.out_blue !== exp.out_blue) report("blue", o_data, exp);
                else if (o_data.frame_end !== exp.frame_end) report("frame_end", o_data, exp);
            end
        end
    end

    // Receiver stall: random bursts, or a long hold-off
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 11);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Send one word; the model steps at acceptance
    task automatic send_word(input t_in w);
        int n;
        if (!calm && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 11);
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= w;
        do @(posedge i_clk); while (o_stall);
        predict_filter(w);
        sent++;
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_IDX_WIDTH) pr_width = val[11:0];
        else if (idx == CFG_IDX_HEIGHT) pr_height = val;
        col_pos = 0; row_pos = 0; owed = 0;
    endtask

    function automatic t_in rand_pix();
        t_in w;
        w.operation = OP_PUSH;
        w.in_red = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 1) * 255) : 8'($urandom);
        w.in_green = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        w.in_blue = 8'($urandom);
        return w;
    endfunction

    function automatic t_in drain_word();
        t_in w;
        w = t_in'($urandom);
        w.operation = OP_DRAIN;
        return w;
    endfunction

    // Full frame plus its drain ticks
    task automatic run_frame(input int unsigned wd, input int unsigned ht);
        for (int i = 0; i < wd * ht; i++) send_word(rand_pix());
        for (int i = 0; i <= wd; i++) send_word(drain_word());
    endtask

    task automatic set_size(input int unsigned wd, input int unsigned ht);
        go_idle();
        write_reg(CFG_IDX_WIDTH, 16'(wd));
        write_reg(CFG_IDX_HEIGHT, 16'(ht));
    endtask

    // Extremes of the pixel fields, drain with nothing owed, early pixels
    task automatic test_directed();
        t_in w;
        set_size(3, 3);
        send_word(drain_word());
        for (int i = 0; i < 9; i++) begin
            w.operation = OP_PUSH;
            w.in_red = (i % 2) ? 8'hFF : 8'h00;
            w.in_green = (i % 3) ? 8'h80 : 8'h7F;
            w.in_blue = (i % 4) ? 8'hFF : 8'h01;
            send_word(w);
        end
        for (int i = 0; i < 4; i++) send_word(drain_word());
        set_size(1, 1);
        send_word(rand_pix());
        send_word(drain_word());
        send_word(drain_word());
    endtask

    // Push during drain restarts the frame; odd register values
    task automatic test_specials();
        set_size(4, 3);
        for (int i = 0; i < 12; i++) send_word(rand_pix());
        send_word(drain_word());
        run_frame(4, 3);
        set_size(0, 0);
        run_frame(1, 1);
        // Upper bits of the width write are dropped: 16'h1005 gives width 5
        go_idle();
        write_reg(CFG_IDX_WIDTH, 16'h1005);
        write_reg(CFG_IDX_HEIGHT, 16'd2);
        run_frame(5, 2);
        // Width above the line buffer clamps; a partial first row gives nothing
        go_idle();
        write_reg(CFG_IDX_WIDTH, 16'hFFFF);
        write_reg(CFG_IDX_HEIGHT, 16'd2);
        for (int i = 0; i < 40; i++) send_word(rand_pix());
        send_word(drain_word());
        set_size(5, 1);
        run_frame(5, 1);
    endtask

    // Random frames of small sizes, some replaced by a random mix of pushes and drains
    task automatic test_random();
        int unsigned wd, ht;
        while (sent < 1400) begin
            wd = $urandom_range(1, 9);
            ht = $urandom_range(1, 7);
            set_size(wd, ht);
            if ($urandom_range(0, 4) == 0) begin
                for (int i = 0; i < 20; i++)
                    send_word($urandom_range(0, 2) ? rand_pix() : drain_word());
            end else begin
                run_frame(wd, ht);
            end
        end
        set_size(16'hFFFF, 16'hFFFF);
    endtask

    // Long receiver hold-off so the queue fills and o_stall rises
    task automatic test_backpressure();
        set_size(8, 6);
        hold_rx = 1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_rx = 0;
            end
            run_frame(8, 6);
        join
        go_idle();
    endtask

    task automatic test_calm();
        calm = 1;
        set_size(6, 5);
        run_frame(6, 5);
        go_idle();
    endtask

    initial begin
        pr_width = 12'd640;
        pr_height = 16'd480;
        col_pos = 0; row_pos = 0; owed = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) win[i][j] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_specials();
        test_backpressure();
        test_random();
        test_calm();
        if (errors == 0 && pixel_q.size() == 0)
            $display("rgb_median3x3_filter verification clean");
        else
            $display("rgb_median3x3_filter verification failed");
        $finish;
    end
endmodule
